@@ hw/rtl/ci64_pkg.sv @@
// ----------------------------------------------------------------------------
// ci64_pkg
// types, opcodes and status codes shared by the checked 64-bit alu
// ----------------------------------------------------------------------------
package ci64_pkg;

	localparam int unsigned W = 64;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_MOD = 3'd4;
	localparam logic [2:0] OP_POW = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_OVF     = 2'd1;
	localparam logic [1:0] ST_DIVZERO = 2'd2;
	localparam logic [1:0] ST_NEGEXP  = 2'd3;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [63:0] lhs;
		logic signed [63:0] rhs;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic [1:0]         status;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture operands, take magnitudes
		logic mul_init; // start a multiply
		logic mul_sel;  // 0: acc * cur, 1: cur * cur
		logic mul_step; // one partial product
		logic mul_fin;  // apply multiply result
		logic div_init;
		logic div_step;
		logic pow_shift; // shift exponent right
		logic finish;    // form result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] op;
		logic       mul_last;
		logic       div_last;
		logic       exp_zero;   // remaining exponent is zero
		logic       exp_lsb;
		logic       exp_one;    // remaining exponent is zero or one
		logic       ovf;        // pow overflow seen
	} dp_status_t;

endpackage

@@ hw/rtl/checked_int64_alu_unit.sv @@
// ----------------------------------------------------------------------------
// checked_int64_alu_unit
// overflow-checked 64-bit signed alu: add, sub, mul, div, mod, pow
// ----------------------------------------------------------------------------
// channel   ports                    handshake
// request   start, busy, req         taken when start high and busy low
// result    done, rsp                one cycle, receiver cannot stall
//
// div and mod form one quotient bit a cycle.
// pow runs one round per exponent bit on the four-step 32x32 multiplier: a
// clear bit squares, a set bit accumulates then squares, the top bit only
// accumulates; a negative exponent still walks its bits until overflow is seen.
// reset clears the sequencer only; busy stays high until the result strobe.
module checked_int64_alu_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  ci64_pkg::in_item_t    req,
	output logic                  done,
	output ci64_pkg::out_item_t   rsp
);

	ci64_pkg::dp_cmd_t    cmd;
	ci64_pkg::dp_status_t stat;
	ci64_pkg::out_item_t  res;
	ci64_pkg::out_item_t  rsp_q;

	ci64_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat),
		.strobe (done)
	);

	ci64_dpath u_dpath (
		.clk     (clk),
		.in_item (req),
		.cmd     (cmd),
		.stat    (stat),
		.result  (res)
	);

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q <= res;
		end
	end

	assign rsp = rsp_q;

endmodule

@@ hw/rtl/ci64_ctrl.sv @@
// ----------------------------------------------------------------------------
// ci64_ctrl
// sequencer for operand load, multiply, divide and square-and-multiply
// ----------------------------------------------------------------------------
module ci64_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	output ci64_pkg::dp_cmd_t      cmd,
	input  ci64_pkg::dp_status_t   stat,
	output logic                   strobe
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DISP = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_PEXP = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;
	localparam logic [2:0] S_PSQ  = 3'd6;

	logic [2:0] state_q, state_d;
	logic       strobe_q, strobe_d;
	logic       sq_q, sq_d; // multiply in progress is the squaring

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strobe_q <= 1'b0;
			sq_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= strobe_d;
			sq_q     <= sq_d;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;

	always_comb begin
		state_d  = state_q;
		strobe_d = 1'b0;
		sq_d     = sq_q;
		cmd      = '0;
		cmd.mul_sel = sq_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				if (stat.op == ci64_pkg::OP_MUL) begin
					cmd.mul_init = 1'b1;
					sq_d         = 1'b0;
					cmd.mul_sel  = 1'b0;
					state_d      = S_MUL;
				end else if (stat.op == ci64_pkg::OP_DIV || stat.op == ci64_pkg::OP_MOD) begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end else if (stat.op == ci64_pkg::OP_POW) begin
					state_d = S_PEXP;
				end else begin
					state_d = S_FIN;
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (stat.mul_last) begin
					state_d = (stat.op == ci64_pkg::OP_POW) ? S_PSQ : S_FIN;
				end
			end
			S_PSQ: begin
				// apply multiply, then decide next round
				cmd.mul_fin = 1'b1;
				if (sq_q) begin
					state_d = S_PEXP;
				end else if (stat.exp_one) begin
					state_d = S_FIN;
				end else begin
					// low exponent bit is now clear, so the next pass starts the squaring
					state_d = S_PEXP;
				end
			end
			S_PEXP: begin
				// shift exponent after a squaring, then start the next round
				if (sq_q) begin
					cmd.pow_shift = 1'b1;
					sq_d          = 1'b0;
				end else if (stat.ovf || stat.exp_zero) begin
					state_d = S_FIN;
				end else if (stat.exp_lsb) begin
					cmd.mul_init = 1'b1;
					cmd.mul_sel  = 1'b0;
					state_d      = S_MUL;
				end else if (stat.exp_one) begin
					state_d = S_FIN;
				end else begin
					cmd.mul_init = 1'b1;
					cmd.mul_sel  = 1'b1;
					sq_d         = 1'b1;
					state_d      = S_MUL;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				strobe_d   = 1'b1;
				sq_d       = 1'b0;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/ci64_dpath.sv @@
// ----------------------------------------------------------------------------
// ci64_dpath
// operand registers, 32x32 partial-product multiplier, restoring divider
// ----------------------------------------------------------------------------
module ci64_dpath (
	input  logic                   clk,
	input  ci64_pkg::in_item_t     in_item,
	input  ci64_pkg::dp_cmd_t      cmd,
	output ci64_pkg::dp_status_t   stat,
	output ci64_pkg::out_item_t    result
);

	logic [2:0]  op_q;
	logic [63:0] a_q, b_q;
	logic        sa_q, sb_q;
	logic [63:0] ma_q, mb_q;

	// multiplier: magnitudes, four 32x32 partial products into 128 bits
	logic [63:0]  mx_q, my_q;
	logic         mneg_q;
	logic [127:0] macc_q;
	logic [1:0]   mcnt_q;
	logic [31:0]  mx_h, my_h;
	logic [63:0]  pp;
	logic [127:0] pp_sh;

	// pow state (signed bit patterns)
	logic [63:0] acc_q, cur_q, ex_q;
	logic        povf_q;

	// divider
	logic [63:0] quo_q, rem_q;
	logic [6:0]  dcnt_q;
	logic [64:0] rtrial;
	logic [64:0] rsub;

	logic [63:0] mul_src_x, mul_src_y;
	logic [63:0] mag_x, mag_y;
	logic [63:0] limit;
	logic        mfit;
	logic [63:0] mval;

	assign mul_src_x = (op_q == ci64_pkg::OP_POW) ? (cmd.mul_sel ? cur_q : acc_q) : a_q;
	assign mul_src_y = (op_q == ci64_pkg::OP_POW) ? cur_q : b_q;
	assign mag_x = mul_src_x[63] ? (64'd0 - mul_src_x) : mul_src_x;
	assign mag_y = mul_src_y[63] ? (64'd0 - mul_src_y) : mul_src_y;

	assign mx_h  = mcnt_q[0] ? mx_q[63:32] : mx_q[31:0];
	assign my_h  = mcnt_q[1] ? my_q[63:32] : my_q[31:0];
	assign pp    = {32'd0, mx_h} * {32'd0, my_h};
	assign pp_sh = {64'd0, pp} << ({5'd0, mcnt_q[0]} * 7'd32 + {5'd0, mcnt_q[1]} * 7'd32);

	assign limit = mneg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
	assign mfit  = (macc_q[127:64] == 64'd0) && (macc_q[63:0] <= limit);
	assign mval  = mneg_q ? (64'd0 - macc_q[63:0]) : macc_q[63:0];

	assign rtrial = {rem_q, quo_q[63]};
	assign rsub   = rtrial - {1'b0, mb_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_item.op;
			a_q  <= in_item.lhs;
			b_q  <= in_item.rhs;
			sa_q <= in_item.lhs[63];
			sb_q <= in_item.rhs[63];
			ma_q <= in_item.lhs[63] ? (64'd0 - in_item.lhs) : in_item.lhs;
			mb_q <= in_item.rhs[63] ? (64'd0 - in_item.rhs) : in_item.rhs;
			acc_q  <= 64'd1;
			cur_q  <= in_item.lhs;
			ex_q   <= in_item.rhs;
			povf_q <= 1'b0;
		end
		if (cmd.mul_init) begin
			mx_q   <= mag_x;
			my_q   <= mag_y;
			mneg_q <= mul_src_x[63] ^ mul_src_y[63];
			macc_q <= '0;
			mcnt_q <= 2'd0;
		end else if (cmd.mul_step) begin
			macc_q <= macc_q + pp_sh;
			mcnt_q <= mcnt_q + 2'd1;
		end
		if (cmd.mul_fin) begin
			if (!mfit) begin
				povf_q <= 1'b1;
			end else if (cmd.mul_sel) begin
				cur_q <= mval;
			end else begin
				acc_q <= mval;
			end
			// a round without squaring consumes the exponent's low bit here
			if (!cmd.mul_sel) begin
				ex_q <= {ex_q[63:1], 1'b0};
			end
		end
		if (cmd.pow_shift) begin
			ex_q <= {1'b0, ex_q[63:1]};
		end
		if (cmd.div_init) begin
			quo_q  <= ma_q;
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			if (!rsub[64]) begin
				rem_q <= rsub[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rtrial[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
			dcnt_q <= dcnt_q + 7'd1;
		end
	end

	assign stat.op       = op_q;
	assign stat.mul_last = (mcnt_q == 2'd3);
	assign stat.div_last = (dcnt_q == 7'd63);
	assign stat.exp_zero = (ex_q == 64'd0);
	assign stat.exp_lsb  = ex_q[0];
	assign stat.exp_one  = (ex_q[63:1] == 63'd0);
	assign stat.ovf      = povf_q;

	// result forming
	logic [63:0] sum, dif, q_s, r_s, r_f;
	logic        bzero, minneg1;

	assign sum     = a_q + b_q;
	assign dif     = a_q - b_q;
	assign bzero   = (b_q == 64'd0);
	assign minneg1 = (a_q == 64'h8000_0000_0000_0000) && (b_q == 64'hFFFF_FFFF_FFFF_FFFF);
	assign q_s     = (sa_q ^ sb_q) ? (64'd0 - quo_q) : quo_q;
	assign r_s     = sa_q ? (64'd0 - rem_q) : rem_q;
	assign r_f     = ((rem_q != 64'd0) && (sa_q != sb_q)) ? (r_s + b_q) : r_s;

	always_comb begin
		result.value  = '0;
		result.status = ci64_pkg::ST_OK;
		case (op_q)
			ci64_pkg::OP_ADD: begin
				if (a_q[63] == b_q[63] && sum[63] != a_q[63]) begin
					result.status = ci64_pkg::ST_OVF;
				end else begin
					result.value = sum;
				end
			end
			ci64_pkg::OP_SUB: begin
				if (a_q[63] != b_q[63] && dif[63] != a_q[63]) begin
					result.status = ci64_pkg::ST_OVF;
				end else begin
					result.value = dif;
				end
			end
			ci64_pkg::OP_MUL: begin
				if (!mfit) begin
					result.status = ci64_pkg::ST_OVF;
				end else begin
					result.value = mval;
				end
			end
			ci64_pkg::OP_DIV: begin
				if (bzero) begin
					result.status = ci64_pkg::ST_DIVZERO;
				end else if (minneg1) begin
					result.status = ci64_pkg::ST_OVF;
				end else begin
					result.value = q_s;
				end
			end
			ci64_pkg::OP_MOD: begin
				if (bzero) begin
					result.status = ci64_pkg::ST_DIVZERO;
				end else if (!minneg1) begin
					result.value = r_f;
				end
			end
			ci64_pkg::OP_POW: begin
				if (b_q[63]) begin
					result.status = ci64_pkg::ST_NEGEXP;
				end else if (povf_q) begin
					result.status = ci64_pkg::ST_OVF;
				end else begin
					result.value = acc_q;
				end
			end
			default: begin
				result.value = '0;
			end
		endcase
	end

endmodule
